// File: sv/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types, codes and the control store for the 4x4 matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int DIM_DEFAULT = 4;
  localparam int ELEM_W      = 32;
  localparam int IDX_W       = 2;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int FRAC_BITS   = 16;

  localparam logic [ELEM_W-1:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_WR_LEFT  = 2'd0,
    OP_WR_RIGHT = 2'd1,
    OP_MULTIPLY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_WAIT = 3'd0,
    S_CLR  = 3'd1,
    S_MUL  = 3'd2,
    S_ACC  = 3'd3,
    S_EMIT = 3'd4,
    S_NEXT = 3'd5
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_MUL_BEAT = 3'd1,
    C_K_ZERO   = 3'd2,
    C_OUT_BUSY = 3'd3,
    C_LAST     = 3'd4
  } cond_t;

  // one control word: datapath strobes, then the branch
  typedef struct packed {
    logic  rdy;
    logic  clr;
    logic  mul;
    logic  acc;
    logic  inc_k;
    logic  emit;
    logic  adv;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } uword_t;

  typedef struct packed {
    logic clr_acc;
    logic do_mul;
    logic do_acc;
    logic wr_left;
    logic wr_right;
  } dp_ctrl_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{rdy: 1'b0, clr: 1'b0, mul: 1'b0, acc: 1'b0, inc_k: 1'b0, emit: 1'b0,
          adv: 1'b0, cond: C_ALWAYS, jmp: S_WAIT, nxt: S_WAIT};
    case (s)
      S_WAIT: begin
        w.rdy  = 1'b1;
        w.cond = C_MUL_BEAT;
        w.jmp  = S_CLR;
        w.nxt  = S_WAIT;
      end
      S_CLR: begin
        w.clr = 1'b1;
        w.jmp = S_MUL;
      end
      S_MUL: begin
        w.mul   = 1'b1;
        w.inc_k = 1'b1;
        w.jmp   = S_ACC;
      end
      S_ACC: begin
        w.acc  = 1'b1;
        w.cond = C_K_ZERO;
        w.jmp  = S_EMIT;
        w.nxt  = S_MUL;
      end
      S_EMIT: begin
        w.emit = 1'b1;
        w.cond = C_OUT_BUSY;
        w.jmp  = S_EMIT;
        w.nxt  = S_NEXT;
      end
      S_NEXT: begin
        w.adv  = 1'b1;
        w.cond = C_LAST;
        w.jmp  = S_WAIT;
        w.nxt  = S_CLR;
      end
      default: begin
        w.jmp = S_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// File: sv/mm4_mac.sv
// ----------------------------------------------------------------------------
// mm4_mac
// Element stores for both matrices and the multiply-accumulate datapath,
// with round-to-nearest, Q15.16 rescale and saturation of the sum.
// ----------------------------------------------------------------------------
module mm4_mac
  import mm4_pkg::*;
#(
  parameter int DIM = DIM_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_ctrl_t                 ctrl,
  input  logic [IDX_W-1:0]         wr_row,
  input  logic [IDX_W-1:0]         wr_col,
  input  logic signed [ELEM_W-1:0] wr_value,
  input  logic [$clog2(DIM)-1:0]   r,
  input  logic [$clog2(DIM)-1:0]   c,
  input  logic [$clog2(DIM)-1:0]   k,
  output logic [ELEM_W-1:0]        result
);

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int ACCW  = PROD_W + 1 + $clog2(DIM);
  localparam int RW    = ACCW - FRAC_BITS;
  localparam logic [ACCW-1:0] HALF = ACCW'(1) << (FRAC_BITS - 1);

  logic [ELEM_W-1:0] left_mem  [DEPTH];
  logic [ELEM_W-1:0] right_mem [DEPTH];
  logic [DEPTH-1:0]  left_vld;
  logic [DEPTH-1:0]  right_vld;

  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     a_addr;
  logic [AW-1:0]     b_addr;
  logic [ELEM_W-1:0] a_data;
  logic [ELEM_W-1:0] b_data;
  logic              a_vld;
  logic              b_vld;
  logic              a_diag;
  logic              b_diag;
  logic [ELEM_W-1:0] a_op;
  logic [ELEM_W-1:0] b_op;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACCW-1:0]   acc;
  logic [ACCW-1:0]          rnd;
  logic [RW-1:0]            rnd_sh;
  logic [RW-32:0]           upper;

  assign wr_addr = AW'(int'(wr_row) * DIM + int'(wr_col));
  assign a_addr  = AW'(int'(r) * DIM + int'(k));
  assign b_addr  = AW'(int'(k) * DIM + int'(c));

  always_ff @(posedge clk) begin
    if (ctrl.wr_left) begin
      left_mem[wr_addr] <= wr_value;
    end
    if (ctrl.wr_right) begin
      right_mem[wr_addr] <= wr_value;
    end
    a_data <= left_mem[a_addr];
    b_data <= right_mem[b_addr];
    a_vld  <= left_vld[a_addr];
    b_vld  <= right_vld[b_addr];
    a_diag <= (r == k);
    b_diag <= (k == c);
  end

  // entries never written read as identity
  always_ff @(posedge clk) begin
    if (rst) begin
      left_vld  <= '0;
      right_vld <= '0;
    end else begin
      if (ctrl.wr_left) begin
        left_vld[wr_addr] <= 1'b1;
      end
      if (ctrl.wr_right) begin
        right_vld[wr_addr] <= 1'b1;
      end
    end
  end

  assign a_op = a_vld ? a_data : (a_diag ? ONE_Q16 : '0);
  assign b_op = b_vld ? b_data : (b_diag ? ONE_Q16 : '0);

  always_ff @(posedge clk) begin
    if (ctrl.do_mul) begin
      prod <= $signed(a_op) * $signed(b_op);
    end
    if (ctrl.clr_acc) begin
      acc <= '0;
    end else if (ctrl.do_acc) begin
      acc <= acc + {{(ACCW-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // exact sum, halves up, then drop the fraction and clamp to 32 bits
  assign rnd    = acc + HALF;
  assign rnd_sh = rnd[ACCW-1:FRAC_BITS];
  assign upper  = rnd_sh[RW-1:31];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      result = rnd_sh[31:0];
    end else if (rnd_sh[RW-1]) begin
      result = SAT_MIN;
    end else begin
      result = SAT_MAX;
    end
  end

endmodule

// File: sv/matrix_multiply_4x4_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_core
// Stored left and right Q15.16 matrices, product emitted in row-major order.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): operation 0 or 1 writes one element of
// the left or right matrix at row/col; an index past the matrix size is
// dropped. Operation 2 starts a multiply; operation 3 is swallowed. in_ready
// is high only while the sequencer waits for a beat.
// Output channel (out_valid/out_ready): one beat per product element,
// out_row/out_col give its place, last marks the final one.
// A multiply is run by a small microprogram: per element one clear step,
// DIM multiply/accumulate step pairs on the one 32x32 multiplier, one emit
// step and one step to advance the indices, for each of the DIM*DIM elements.
// A stalled receiver holds the sequencer at its emit step; the output
// register lets element writes be taken while the last beat still waits.
// Reset sets both matrices to identity and clears the output valid flag.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_core
  import mm4_pkg::*;
#(
  parameter int DIM = DIM_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               operation,
  input  logic [IDX_W-1:0]         row,
  input  logic [IDX_W-1:0]         col,
  input  logic signed [ELEM_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [ELEM_W-1:0] product,
  output logic                     last
);

  localparam int CW = $clog2(DIM);
  localparam logic [CW-1:0] IDX_MAX = CW'(DIM - 1);

  step_t         step;
  step_t         step_next;
  uword_t        uw;
  logic [CW-1:0] r;
  logic [CW-1:0] c;
  logic [CW-1:0] k;
  logic          in_beat;
  logic          in_range;
  logic          out_free;
  logic          at_last;
  logic          cond_ok;
  dp_ctrl_t      dp_ctrl;
  logic [ELEM_W-1:0] result;

  assign uw       = ucode(step);
  assign in_ready = uw.rdy && !rst;
  assign in_beat  = in_valid && in_ready;
  assign in_range = (int'(row) < DIM) && (int'(col) < DIM);
  assign out_free = !out_valid || out_ready;
  assign at_last  = (r == IDX_MAX) && (c == IDX_MAX);

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   cond_ok = 1'b1;
      C_MUL_BEAT: cond_ok = in_beat && (operation == OP_MULTIPLY);
      C_K_ZERO:   cond_ok = (k == '0);
      C_OUT_BUSY: cond_ok = !out_free;
      C_LAST:     cond_ok = at_last;
      default:    cond_ok = 1'b0;
    endcase
    step_next = cond_ok ? uw.jmp : uw.nxt;
  end

  always_comb begin
    dp_ctrl.clr_acc  = uw.clr;
    dp_ctrl.do_mul   = uw.mul;
    dp_ctrl.do_acc   = uw.acc;
    dp_ctrl.wr_left  = in_beat && in_range && (operation == OP_WR_LEFT);
    dp_ctrl.wr_right = in_beat && in_range && (operation == OP_WR_RIGHT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_WAIT;
      r         <= '0;
      c         <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (uw.inc_k) begin
        k <= (k == IDX_MAX) ? '0 : k + 1'b1;
      end
      // counters wrap back to zero after the last element
      if (uw.adv) begin
        if (c == IDX_MAX) begin
          c <= '0;
          r <= (r == IDX_MAX) ? '0 : r + 1'b1;
        end else begin
          c <= c + 1'b1;
        end
      end
      if (uw.emit && out_free) begin
        out_valid <= 1'b1;
        out_row   <= IDX_W'(r);
        out_col   <= IDX_W'(c);
        product   <= $signed(result);
        last      <= at_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  mm4_mac #(
    .DIM (DIM)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (dp_ctrl),
    .wr_row   (row),
    .wr_col   (col),
    .wr_value (value),
    .r        (r),
    .c        (c),
    .k        (k),
    .result   (result)
  );

`ifndef SYNTHESIS
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (step == S_EMIT && out_free) |=> out_valid)
    else $error("emit step did not load the output register");

  a_acc_done: assert property (@(posedge clk) disable iff (rst)
    (step == S_ACC && k == '0) |=> (step == S_EMIT))
    else $error("accumulation did not end after the last term");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (out_row == IDX_W'(DIM - 1) && out_col == IDX_W'(DIM - 1)))
    else $error("last flag on an element that is not the final one");

  a_no_mac_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (k == '0 && r == '0 && c == '0))
    else $error("indices not rewound while waiting for a beat");
`endif

endmodule

// File: tb/tb_matrix_multiply_4x4_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_4x4_core
// Loads elements of the left and right Q15.16 matrices and triggers multiplies.
// A directed table covers the saturation bounds, rounding of halves and the
// unused code, then random bursts of loads each end in a multiply. Every
// product beat is checked against a local fixed-point predictor or a pinned value.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_4x4_core
  import mm4_pkg::*;
();

  localparam int N = DIM_DEFAULT;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LOAD_ITEMS = 400;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]        op;
    logic [IDX_W-1:0]  r;
    logic [IDX_W-1:0]  c;
    logic [ELEM_W-1:0] v;
    logic              pin;    // element (0,0) typed in below
    logic [ELEM_W-1:0] pin_v;
  } stim_row_t;

  typedef struct packed {
    logic [IDX_W-1:0]  r;
    logic [IDX_W-1:0]  c;
    logic [ELEM_W-1:0] p;
    logic              lst;
  } elem_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               operation = OP_WR_LEFT;
  logic [IDX_W-1:0]         row = '0;
  logic [IDX_W-1:0]         col = '0;
  logic signed [ELEM_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [ELEM_W-1:0] product;
  logic                     last;

  logic signed [ELEM_W-1:0] left_m [N][N];
  logic signed [ELEM_W-1:0] right_m [N][N];
  elem_t                    elems_due [$];
  int                       mismatches = 0;
  int                       beats_seen = 0;
  int                       send_idle = 28;
  int                       recv_idle = 50;

  stim_row_t script [24] = '{
    '{OP_MULTIPLY, 0, 0, 32'h0,         1, ONE_Q16},  // identity times identity
    '{OP_UNUSED,   3, 3, 32'hFFFF_FFFF, 0, 0},
    '{OP_WR_LEFT,  0, 0, SAT_MAX,       0, 0},
    '{OP_WR_RIGHT, 0, 0, SAT_MAX,       0, 0},
    '{OP_MULTIPLY, 3, 3, 32'hDEAD_BEEF, 1, SAT_MAX},
    '{OP_WR_RIGHT, 0, 0, SAT_MIN,       0, 0},
    '{OP_MULTIPLY, 0, 0, 32'h0,         1, SAT_MIN},
    '{OP_WR_LEFT,  0, 0, SAT_MIN,       0, 0},
    '{OP_MULTIPLY, 0, 0, 32'h0,         1, SAT_MAX},
    '{OP_WR_LEFT,  0, 0, 32'h1,         0, 0},
    '{OP_WR_RIGHT, 0, 0, 32'h8000,      0, 0},
    '{OP_MULTIPLY, 0, 0, 32'h0,         1, 32'h1},    // half rounds up
    '{OP_WR_LEFT,  0, 0, 32'hFFFF_FFFF, 0, 0},
    '{OP_MULTIPLY, 0, 0, 32'h0,         1, 32'h0},    // minus half goes to zero
    '{OP_WR_LEFT,  0, 0, ONE_Q16,       0, 0},
    '{OP_WR_RIGHT, 0, 0, ONE_Q16,       0, 0},
    '{OP_WR_LEFT,  3, 3, 32'hFFFF_FFFF, 0, 0},
    '{OP_WR_RIGHT, 3, 0, SAT_MAX,       0, 0},
    '{OP_WR_LEFT,  1, 2, SAT_MIN,       0, 0},
    '{OP_WR_RIGHT, 2, 1, 32'h1234_5678, 0, 0},
    '{OP_MULTIPLY, 2, 1, 32'h0,         0, 0},
    '{OP_UNUSED,   0, 0, 32'h0,         0, 0},
    '{OP_WR_RIGHT, 0, 3, 32'h0,         0, 0},
    '{OP_MULTIPLY, 1, 2, SAT_MAX,       0, 0}
  };

  always #5 clk = ~clk;

  matrix_multiply_4x4_core #(.DIM(N)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .row       (row),
    .col       (col),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .product   (product),
    .last      (last)
  );

  // exact dot product, round half up, drop 16 fraction bits, saturate
  function automatic logic [ELEM_W-1:0] element_q16(input int r, input int c);
    logic signed [67:0] acc;
    logic signed [67:0] q;
    logic signed [63:0] a;
    logic signed [63:0] b;
    acc = '0;
    for (int k = 0; k < N; k++) begin
      a = left_m[r][k];
      b = right_m[k][c];
      acc = acc + a * b;
    end
    q = (acc + 68'sd32768) >>> FRAC_BITS;
    if (q > 68'sd2147483647) return SAT_MAX;
    if (q < -68'sd2147483648) return SAT_MIN;
    return q[ELEM_W-1:0];
  endfunction

  task automatic offer(input logic [1:0] op, input logic [IDX_W-1:0] r,
                       input logic [IDX_W-1:0] c, input logic [ELEM_W-1:0] v,
                       input logic pin, input logic [ELEM_W-1:0] pin_v);
    elem_t e;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    row       <= r;
    col       <= c;
    value     <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_WR_LEFT:  left_m[r][c] = v;
      OP_WR_RIGHT: right_m[r][c] = v;
      OP_MULTIPLY: begin
        for (int i = 0; i < N; i++) begin
          for (int j = 0; j < N; j++) begin
            e.r   = i[IDX_W-1:0];
            e.c   = j[IDX_W-1:0];
            e.p   = (pin && i == 0 && j == 0) ? pin_v : element_q16(i, j);
            e.lst = (i == N - 1) && (j == N - 1);
            elems_due.push_back(e);
          end
        end
      end
      default: ;  // unused code: no beats
    endcase
  endtask

  initial begin
    int                n;
    int                burst;
    logic [1:0]        op;
    logic [ELEM_W-1:0] v;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        left_m[i][j]  = (i == j) ? ONE_Q16 : '0;
        right_m[i][j] = (i == j) ? ONE_Q16 : '0;
      end
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i])
      offer(script[i].op, script[i].r, script[i].c, script[i].v,
            script[i].pin, script[i].pin_v);

    n = 0;
    while (n < LOAD_ITEMS) begin
      if (n >= 2 * LOAD_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (n >= LOAD_ITEMS / 3) begin
        send_idle = 50;
        recv_idle = 28;
      end
      burst = $urandom_range(16);
      for (int b = 0; b < burst; b++) begin
        case ($urandom_range(3))
          0: v = $urandom();
          1: v = $urandom_range(1 << 19) - (1 << 18);
          2: begin
            case ($urandom_range(4))
              0: v = SAT_MAX;
              1: v = SAT_MIN;
              2: v = '0;
              3: v = ONE_Q16;
              default: v = -ONE_Q16;
            endcase
          end
          default: v = ($urandom_range(16) - 8) << FRAC_BITS;
        endcase
        if ($urandom_range(99) < 4) begin
          offer(OP_UNUSED, IDX_W'($urandom_range(3)), IDX_W'($urandom_range(3)), v,
                1'b0, '0);
        end else begin
          op = $urandom_range(1) ? OP_WR_RIGHT : OP_WR_LEFT;
          offer(op, IDX_W'($urandom_range(3)), IDX_W'($urandom_range(3)), v, 1'b0, '0);
          n++;
        end
      end
      offer(OP_MULTIPLY, IDX_W'($urandom_range(3)), IDX_W'($urandom_range(3)),
            $urandom(), 1'b0, '0);
      n++;
    end

    in_valid <= 1'b0;
    while (elems_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // receiver; one long hold-off so the core backs up and drops in_ready
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && beats_seen >= 200) begin
        held = 1'b1;
        out_ready <= 1'b0;
        for (int i = 1; i < HOLD_CYCLES; i++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    elem_t want;
    if (!rst && out_valid && out_ready) begin
      beats_seen <= beats_seen + 1;
      if (elems_due.size() == 0) begin
        $display("%0t: product beat with none due, expected none, actual (%0d,%0d) %h",
                 $time, out_row, out_col, product);
        mismatches++;
      end else begin
        want = elems_due.pop_front();
        if (out_row !== want.r) begin
          $display("%0t: out_row expected %0d actual %0d", $time, want.r, out_row);
          mismatches++;
        end
        if (out_col !== want.c) begin
          $display("%0t: out_col expected %0d actual %0d", $time, want.c, out_col);
          mismatches++;
        end
        if (product !== want.p) begin
          $display("%0t: product (%0d,%0d) expected %h actual %h",
                   $time, want.r, want.c, want.p, product);
          mismatches++;
        end
        if (last !== want.lst) begin
          $display("%0t: last (%0d,%0d) expected %b actual %b",
                   $time, want.r, want.c, want.lst, last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
